// File: rtl/core/bcp_pkg.sv
package bcp_pkg;

  // Default table depth (entries with nonzero size)
  localparam int TABLE_DEPTH_DEF = 128;

  // Header layout
  localparam logic [3:0]  HDR_MAGIC_POS   = 4'd3;
  localparam logic [3:0]  HDR_VERSION_POS = 4'd7;
  localparam logic [3:0]  HDR_COUNT_POS   = 4'd11;
  localparam logic [31:0] MAGIC_WORD      = 32'h5053_4249;  // "IBSP", little endian

  // Byte offsets inside one table entry
  localparam logic [2:0] ENT_ID_END   = 3'd3;
  localparam logic [2:0] ENT_SIZE_END = 3'd7;

  // Configuration register indexes and reset values
  localparam logic [0:0]  REG_EXPECTED_VERSION = 1'd0;
  localparam logic [0:0]  REG_LUMP_LIMIT       = 1'd1;
  localparam logic [31:0] EXPECTED_VERSION_RST = 32'd22;
  localparam logic [7:0]  LUMP_LIMIT_RST       = 8'd100;

  // Final status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_TOO_SMALL = 3'd1;
  localparam status_t ST_BAD_MAGIC = 3'd2;
  localparam status_t ST_BAD_VER   = 3'd3;
  localparam status_t ST_COUNT_BIG = 3'd4;
  localparam status_t ST_TBL_TRUNC = 3'd5;
  localparam status_t ST_LUMP_END  = 3'd6;
  localparam status_t ST_PAD_END   = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        lump_byte_valid;
    logic [7:0]  lump_byte;
    logic [6:0]  lump_index;
    logic [31:0] lump_id;
    logic        file_done;
    status_t     status;
  } out_item_t;

  // Size and table position, stored together
  typedef struct packed {
    logic [31:0] size;
    logic [6:0]  index;
  } size_rec_t;

  // One full directory entry
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] size;
    logic [6:0]  index;
  } lump_rec_t;

  // Table write request from the parser
  typedef struct packed {
    logic        id_we;
    logic        rec_we;
    logic [31:0] id;
    logic [31:0] size;
    logic [6:0]  index;
  } tbl_wr_t;

endpackage

// File: rtl/core/bsp_lump_container_parser_core.sv
// channel   dir  handshake                  payload
// data      in   data_valid / data_stall    data_item   (bcp_pkg::in_item_t)
// result    out  result_valid / result_stall result_item (bcp_pkg::out_item_t)
// config    in   cfg_we                     cfg_index, cfg_data
//
// One item per cycle while data_stall is low; each byte item gives exactly one
// result item, registered in the output buffer. The next-lump record is prefetched
// from the directory memory while a lump streams; lump changes add no stall.
// Reset: synchronous; no clearing pass, the directory memory is used only
// where written. A two-entry output buffer keeps input flowing while a
// result waits; data_stall rises only when both entries are full.
module bsp_lump_container_parser_core #(
  parameter int TABLE_DEPTH = bcp_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                data_valid,
  output logic                data_stall,
  input  bcp_pkg::in_item_t   data_item,
  output logic                result_valid,
  input  logic                result_stall,
  output bcp_pkg::out_item_t  result_item,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import bcp_pkg::*;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  logic              accept;
  logic              buf_full;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  tbl_wr_t           wr;
  lump_rec_t         rd_rec;
  out_item_t         res_item;

  assign data_stall = buf_full;
  assign accept     = data_valid && !buf_full;

  bcp_parser #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_item (data_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr_addr   (wr_addr),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_rec    (rd_rec),
    .res_item  (res_item)
  );

  bcp_table_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_table_mem (
    .clk     (clk),
    .wr_addr (wr_addr),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_rec  (rd_rec)
  );

  bcp_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .push_item    (res_item),
    .full         (buf_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

// File: rtl/core/bcp_table_mem.sv
module bcp_table_mem #(
  parameter int TABLE_DEPTH = bcp_pkg::TABLE_DEPTH_DEF,
  parameter int ADDR_W      = 7
) (
  input  logic                  clk,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  bcp_pkg::tbl_wr_t      wr,
  input  logic [ADDR_W-1:0]     rd_addr,
  output bcp_pkg::lump_rec_t    rd_rec
);
  import bcp_pkg::*;

  logic [31:0] id_mem  [TABLE_DEPTH];
  size_rec_t   rec_mem [TABLE_DEPTH];

  // id memory written when an entry's id word completes,
  // size/index memory only for nonzero-sized entries
  always_ff @(posedge clk) begin
    if (wr.id_we) begin
      id_mem[wr_addr] <= wr.id;
    end
    if (wr.rec_we) begin
      rec_mem[wr_addr] <= '{size: wr.size, index: wr.index};
    end
    rd_rec.id <= id_mem[rd_addr];
    {rd_rec.size, rd_rec.index} <= rec_mem[rd_addr];
  end

endmodule

// File: rtl/core/bcp_out_buf.sv
module bcp_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bcp_pkg::out_item_t  push_item,
  output logic                full,
  output logic                result_valid,
  input  logic                result_stall,
  output bcp_pkg::out_item_t  result_item
);
  import bcp_pkg::*;

  logic      main_valid;
  out_item_t main_item;
  logic      skid_valid;
  out_item_t skid_item;

  assign full         = skid_valid;
  assign result_valid = main_valid;
  assign result_item  = main_item;

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || !result_stall) begin
      if (skid_valid) begin
        main_item  <= skid_item;
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
        if (push) begin
          main_item <= push_item;
        end
      end
    end else if (push) begin
      skid_item  <= push_item;
      skid_valid <= 1'b1;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held without output entry");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("item pushed into full output buffer");

endmodule

// File: rtl/core/bcp_parser.sv
module bcp_parser #(
  parameter int TABLE_DEPTH = bcp_pkg::TABLE_DEPTH_DEF,
  parameter int ADDR_W      = 7,
  parameter int CNT_W       = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  bcp_pkg::in_item_t   data_item,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic [ADDR_W-1:0]   wr_addr,
  output bcp_pkg::tbl_wr_t    wr,
  output logic [ADDR_W-1:0]   rd_addr,
  input  bcp_pkg::lump_rec_t  rd_rec,
  output bcp_pkg::out_item_t  res_item
);
  import bcp_pkg::*;

  localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    PH_HEADER, PH_TABLE, PH_LUMP, PH_PAD, PH_TAIL, PH_DRAIN
  } phase_t;

  // configuration
  logic [31:0] expected_version;
  logic [7:0]  lump_limit;

  // parse state
  phase_t      phase, phase_next;
  logic [3:0]  hdr_cnt, hdr_cnt_next;       // saturates at HDR_COUNT_POS
  logic [31:0] header_word, header_word_next;
  status_t     first_error, first_error_next;
  logic [CNT_W-1:0] lump_total, lump_total_next;
  logic [CNT_W-1:0] stored_count, stored_count_next;
  logic [CNT_W-1:0] cur_entry, cur_entry_next;
  logic [2:0]  tbl_sub, tbl_sub_next;
  logic [31:0] bytes_left, bytes_left_next;
  lump_rec_t   cur, cur_next;                // record of cur_entry

  logic [CNT_W-1:0] entry_inc;
  logic [CNT_W-1:0] stored_inc;
  logic [31:0]      left_dec;
  logic [1:0]       pad_len;

  assign entry_inc  = cur_entry + CNT_W'(1);
  assign stored_inc = stored_count + CNT_W'(1);
  assign left_dec   = bytes_left - 32'd1;
  assign pad_len    = 2'd0 - cur.size[1:0];

  // prefetch the entry after the current one; lumps span at least four items
  assign rd_addr = entry_inc[ADDR_W-1:0];
  assign wr_addr = stored_count[ADDR_W-1:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= EXPECTED_VERSION_RST;
      lump_limit       <= LUMP_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXPECTED_VERSION: expected_version <= cfg_data;
        REG_LUMP_LIMIT:       lump_limit       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // one byte step
  always_comb begin
    phase_next        = phase;
    hdr_cnt_next      = (hdr_cnt == HDR_COUNT_POS) ? hdr_cnt : hdr_cnt + 4'd1;
    header_word_next  = header_word;
    first_error_next  = first_error;
    lump_total_next   = lump_total;
    stored_count_next = stored_count;
    cur_entry_next    = cur_entry;
    tbl_sub_next      = tbl_sub;
    bytes_left_next   = bytes_left;
    cur_next          = cur;
    wr                = '0;
    res_item          = '0;

    if (phase == PH_HEADER || phase == PH_TABLE) begin
      header_word_next = {data_item.data_byte, header_word[31:8]};
    end

    case (phase)
      PH_HEADER: begin
        if (hdr_cnt == HDR_MAGIC_POS && header_word_next != MAGIC_WORD) begin
          first_error_next = ST_BAD_MAGIC;
          phase_next       = PH_DRAIN;
        end else if (hdr_cnt == HDR_VERSION_POS && header_word_next != expected_version) begin
          first_error_next = ST_BAD_VER;
          phase_next       = PH_DRAIN;
        end else if (hdr_cnt == HDR_COUNT_POS) begin
          if (header_word_next > {24'd0, lump_limit} || header_word_next > DEPTH_W) begin
            first_error_next = ST_COUNT_BIG;
            phase_next       = PH_DRAIN;
          end else begin
            lump_total_next = CNT_W'(header_word_next);
            cur_entry_next  = '0;
            tbl_sub_next    = '0;
            bytes_left_next = '0;
            phase_next      = (header_word_next == 32'd0) ? PH_TAIL : PH_TABLE;
          end
        end
      end

      PH_TABLE: begin
        tbl_sub_next = tbl_sub + 3'd1;
        if (tbl_sub == ENT_ID_END) begin
          wr.id_we = 1'b1;
          wr.id    = header_word_next;
          if (stored_count == '0) begin
            cur_next.id = header_word_next;
          end
        end else if (tbl_sub == ENT_SIZE_END) begin
          if (header_word_next != 32'd0) begin
            wr.rec_we = 1'b1;
            wr.size   = header_word_next;
            wr.index  = 7'(cur_entry);
            if (stored_count == '0) begin
              cur_next.size  = header_word_next;
              cur_next.index = 7'(cur_entry);
            end
            stored_count_next = stored_inc;
          end
          if (entry_inc >= lump_total) begin
            // table done: open the first kept lump, if any
            cur_entry_next = '0;
            if (stored_count_next == '0) begin
              phase_next      = PH_TAIL;
              bytes_left_next = '0;
            end else begin
              phase_next      = PH_LUMP;
              bytes_left_next = cur_next.size;
            end
          end else begin
            cur_entry_next = entry_inc;
          end
        end
      end

      PH_LUMP, PH_PAD: begin
        if (phase == PH_LUMP) begin
          res_item.lump_byte_valid = 1'b1;
          res_item.lump_byte       = data_item.data_byte;
          res_item.lump_index      = cur.index;
          res_item.lump_id         = cur.id;
        end
        if (left_dec != 32'd0) begin
          bytes_left_next = left_dec;
        end else if (phase == PH_LUMP && pad_len != 2'd0) begin
          bytes_left_next = {30'd0, pad_len};
          phase_next      = PH_PAD;
        end else begin
          // advance to the next kept lump
          cur_entry_next = entry_inc;
          if (entry_inc >= stored_count) begin
            phase_next      = PH_TAIL;
            bytes_left_next = '0;
          end else begin
            phase_next      = PH_LUMP;
            cur_next        = rd_rec;
            bytes_left_next = rd_rec.size;
          end
        end
      end

      default: ;
    endcase

    // final status, then back to the start state
    if (data_item.last_byte) begin
      res_item.file_done = 1'b1;
      if (hdr_cnt < HDR_COUNT_POS) begin
        res_item.status = ST_TOO_SMALL;
      end else if (first_error_next != ST_OK) begin
        res_item.status = first_error_next;
      end else begin
        case (phase_next)
          PH_TABLE: res_item.status = ST_TBL_TRUNC;
          PH_LUMP:  res_item.status = ST_LUMP_END;
          PH_PAD:   res_item.status = ST_PAD_END;
          default:  res_item.status = ST_OK;
        endcase
      end
      phase_next        = PH_HEADER;
      hdr_cnt_next      = '0;
      header_word_next  = '0;
      first_error_next  = ST_OK;
      lump_total_next   = '0;
      stored_count_next = '0;
      cur_entry_next    = '0;
      tbl_sub_next      = '0;
      bytes_left_next   = '0;
    end

    if (!accept) begin
      wr.id_we  = 1'b0;
      wr.rec_we = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      hdr_cnt      <= '0;
      header_word  <= '0;
      first_error  <= ST_OK;
      lump_total   <= '0;
      stored_count <= '0;
      cur_entry    <= '0;
      tbl_sub      <= '0;
      bytes_left   <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      hdr_cnt      <= hdr_cnt_next;
      header_word  <= header_word_next;
      first_error  <= first_error_next;
      lump_total   <= lump_total_next;
      stored_count <= stored_count_next;
      cur_entry    <= cur_entry_next;
      tbl_sub      <= tbl_sub_next;
      bytes_left   <= bytes_left_next;
    end
  end

  // current entry record (payload)
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= cur_next;
    end
  end

  a_lump_entry_kept: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LUMP || phase == PH_PAD) |-> cur_entry < stored_count)
    else $error("lump phase on an entry that was never stored");

  a_lump_bytes_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LUMP || phase == PH_PAD) |-> bytes_left != 32'd0)
    else $error("lump or padding phase with nothing left");

  a_stored_in_range: assert property (@(posedge clk) disable iff (rst)
    stored_count <= lump_total && lump_total <= CNT_W'(TABLE_DEPTH))
    else $error("stored entry count beyond lump count or table depth");

endmodule

// File: tb/sv/bsp_lump_container_parser_core_test.sv
module bsp_lump_container_parser_core_test;
  import bcp_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int HDR_BYTES = 12;
  localparam logic [39:0] POS_SAT = '1;
  localparam int ROUND_BYTES = 155;

  // DUT ports; the driven inputs are known from time zero
  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      data_valid = 1'b0;
  logic      data_stall;
  in_item_t  data_item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_item_t result_item;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_EXPECTED_VERSION;
  logic [31:0] cfg_data = '0;

  bsp_lump_container_parser_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_item    (data_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case the DUT hangs
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Parser shadow: register copies and parse state
  typedef enum logic [2:0] {
    PH_HEADER, PH_TABLE, PH_LUMP, PH_PAD, PH_TAIL, PH_DRAIN
  } parse_phase_t;

  logic [31:0]  cfg_version;
  logic [7:0]   cfg_max_count;
  parse_phase_t ph;
  logic [39:0]  pos;
  logic [31:0]  shift_word;
  status_t      err_code;
  logic [7:0]   n_lumps;
  logic [7:0]   n_kept;
  logic [7:0]   entry_no;
  logic [33:0]  left_in_lump;
  logic [31:0]  dir_id   [DEPTH];
  logic [31:0]  dir_size [DEPTH];
  logic [6:0]   dir_pos  [DEPTH];

  function automatic void clear_parse();
    ph = PH_HEADER;
    pos = '0;
    shift_word = '0;
    err_code = ST_OK;
    n_lumps = '0;
    n_kept = '0;
    entry_no = '0;
    left_in_lump = '0;
  endfunction

  function automatic void abort_file(status_t code);
    err_code = code;
    ph = PH_DRAIN;
  endfunction

  function automatic void open_next_lump();
    if (entry_no >= n_kept || entry_no >= DEPTH) begin
      ph = PH_TAIL;
      left_in_lump = '0;
    end else begin
      left_in_lump = {2'b00, dir_size[entry_no[6:0]]};
      ph = PH_LUMP;
    end
  endfunction

  // Expected result item for one accepted byte; advances the shadow state
  function automatic out_item_t parse_byte(in_item_t it);
    out_item_t r;
    logic [39:0] rel;
    logic [31:0] neg_size;
    r = '0;
    if (ph == PH_HEADER || ph == PH_TABLE) shift_word = {it.data_byte, shift_word[31:8]};
    case (ph)
      PH_HEADER: begin
        if (pos == HDR_MAGIC_POS && shift_word != MAGIC_WORD) begin
          abort_file(ST_BAD_MAGIC);
        end else if (pos == HDR_VERSION_POS && shift_word != cfg_version) begin
          abort_file(ST_BAD_VER);
        end else if (pos == HDR_COUNT_POS) begin
          if (shift_word > cfg_max_count || shift_word > DEPTH) begin
            abort_file(ST_COUNT_BIG);
          end else begin
            n_lumps = shift_word[7:0];
            entry_no = '0;
            if (n_lumps == 0) open_next_lump();
            else ph = PH_TABLE;
          end
        end
      end
      PH_TABLE: begin
        rel = pos - HDR_BYTES;
        if (rel[2:0] == ENT_ID_END && n_kept < DEPTH) begin
          dir_id[n_kept[6:0]] = shift_word;
        end else if (rel[2:0] == ENT_SIZE_END) begin
          // zero-sized entries are dropped from the directory
          if (shift_word != 0 && n_kept < DEPTH) begin
            dir_size[n_kept[6:0]] = shift_word;
            dir_pos[n_kept[6:0]] = entry_no[6:0];
            n_kept++;
          end
          entry_no++;
          if (entry_no >= n_lumps) begin
            entry_no = '0;
            open_next_lump();
          end
        end
      end
      PH_LUMP: begin
        if (entry_no < n_kept && entry_no < DEPTH) begin
          r.lump_byte_valid = 1'b1;
          r.lump_byte = it.data_byte;
          r.lump_index = dir_pos[entry_no[6:0]];
          r.lump_id = dir_id[entry_no[6:0]];
          if (left_in_lump > 0) left_in_lump--;
          if (left_in_lump == 0) begin
            neg_size = 32'd0 - dir_size[entry_no[6:0]];
            if (neg_size[1:0] != 2'd0) begin
              left_in_lump = {32'd0, neg_size[1:0]};
              ph = PH_PAD;
            end else begin
              entry_no++;
              open_next_lump();
            end
          end
        end else begin
          ph = PH_TAIL;
        end
      end
      PH_PAD: begin
        if (left_in_lump > 0) left_in_lump--;
        if (left_in_lump == 0) begin
          entry_no++;
          open_next_lump();
        end
      end
      default: ;
    endcase
    if (pos < POS_SAT) pos++;
    if (it.last_byte) begin
      r.file_done = 1'b1;
      if (pos < HDR_BYTES) r.status = ST_TOO_SMALL;
      else if (err_code != ST_OK) r.status = err_code;
      else if (ph == PH_TABLE) r.status = ST_TBL_TRUNC;
      else if (ph == PH_LUMP) r.status = ST_LUMP_END;
      else if (ph == PH_PAD) r.status = ST_PAD_END;
      else r.status = ST_OK;
      clear_parse();
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Expected result store and checking
  typedef struct {
    bit      typed;
    status_t want;
  } file_tag_t;

  typedef struct {
    out_item_t res;
    file_tag_t tag;
  } pend_t;

  pend_t     pending[$];
  file_tag_t file_tags[$];
  int        mismatches = 0;
  int        n_bytes = 0;
  int        n_files = 0;
  int        n_payload = 0;
  logic [7:0] seen_status = '0;

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Results are checked before the new byte is predicted in the same edge
  always @(posedge clk) begin : sample
    pend_t e;
    if (!rst) begin
      if (result_valid === 1'b1 && result_stall === 1'b0) begin
        if (pending.size() == 0) begin
          $error("result item with nothing expected");
          mismatches++;
        end else begin
          e = pending.pop_front();
          check_field("lump_byte_valid", e.res.lump_byte_valid, result_item.lump_byte_valid);
          check_field("lump_byte", e.res.lump_byte, result_item.lump_byte);
          check_field("lump_index", e.res.lump_index, result_item.lump_index);
          check_field("lump_id", e.res.lump_id, result_item.lump_id);
          check_field("file_done", e.res.file_done, result_item.file_done);
          check_field("status", e.res.status, result_item.status);
          if (e.tag.typed) check_field("status (directed)", e.tag.want, result_item.status);
          if (result_item.lump_byte_valid === 1'b1) n_payload++;
          if (result_item.file_done === 1'b1) seen_status[result_item.status] = 1'b1;
        end
      end
      if (data_valid === 1'b1 && data_stall === 1'b0) begin
        e.res = parse_byte(data_item);
        e.tag = '{1'b0, ST_OK};
        if (data_item.last_byte) e.tag = file_tags.pop_front();
        pending.push_back(e);
        n_bytes++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  int send_pct = 0;
  int recv_pct = 0;

  always @(negedge clk) begin
    result_stall <= !rst && ($urandom_range(0, 99) < recv_pct);
  end

  task automatic push_byte(input in_item_t it);
    while ($urandom_range(0, 99) < send_pct) begin
      data_valid = 1'b0;
      @(negedge clk);
    end
    data_valid = 1'b1;
    data_item = it;
    @(posedge clk);
    while (data_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    data_valid = 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(input logic [0:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_EXPECTED_VERSION) cfg_version = val;
    else cfg_max_count = val[7:0];
  endtask

  // ---------------------------------------------------------------------------
  // File building
  logic [7:0] file_bytes[$];

  task automatic add_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) file_bytes.push_back(w[8*k +: 8]);
  endtask

  task automatic add_random(input int n);
    for (int k = 0; k < n; k++) file_bytes.push_back(8'($urandom));
  endtask

  // Payload plus padding; huge lumps get 1 to 12 bytes and flag the file as cut short
  task automatic add_lump(input logic [31:0] size, output bit cut_short);
    logic [31:0] neg_size;
    cut_short = 1'b0;
    if (size > 64) begin
      add_random($urandom_range(1, 12));
      cut_short = 1'b1;
    end else begin
      neg_size = 32'd0 - size;
      add_random(size);
      add_random(neg_size[1:0]);
    end
  endtask

  task automatic keep_first(input int n);
    while (file_bytes.size() > n) void'(file_bytes.pop_back());
  endtask

  task automatic send_file(input file_tag_t tag);
    in_item_t it;
    file_tags.push_back(tag);
    for (int k = 0; k < file_bytes.size(); k++) begin
      it.data_byte = file_bytes[k];
      it.last_byte = (k == file_bytes.size() - 1);
      push_byte(it);
    end
    n_files++;
  endtask

  typedef struct {
    logic [31:0] magic;
    logic [31:0] version;
    logic [31:0] count;
    logic [31:0] id0;
    logic [31:0] sz0;
    logic [31:0] sz1;
    logic [31:0] sz2;
    int          cut;    // 0 keeps the whole file
    int          trail;
    bit          typed;
    status_t     want;
  } dir_row_t;

  task automatic build_row(input dir_row_t r);
    logic [31:0] sz[3];
    bit          short_lump;
    sz = '{r.sz0, r.sz1, r.sz2};
    file_bytes.delete();
    add_word(r.magic);
    add_word(r.version);
    add_word(r.count);
    for (int k = 0; k < 3 && k < r.count; k++) begin
      add_word(r.id0 + k);
      add_word(sz[k]);
    end
    for (int k = 0; k < 3 && k < r.count; k++) begin
      if (sz[k] != 0) add_lump(sz[k], short_lump);
    end
    add_random(r.trail);
    if (r.cut != 0) keep_first(r.cut);
  endtask

  // Directory of the given entry count, almost all entries empty; none past the depth
  task automatic build_big_table(input logic [31:0] cnt);
    logic [31:0] sizes[$];
    logic [31:0] sz;
    bit          short_lump;
    file_bytes.delete();
    add_word(MAGIC_WORD);
    add_word(cfg_version);
    add_word(cnt);
    if (cnt <= DEPTH) begin
      for (int k = 0; k < cnt; k++) begin
        sz = (k == 0 || k == 63 || k == cnt - 1) ? (k % 4) + 1 : 0;
        add_word($urandom);
        add_word(sz);
        sizes.push_back(sz);
      end
      foreach (sizes[k]) if (sizes[k] != 0) add_lump(sizes[k], short_lump);
    end
    add_random(1);
  endtask

  // Mostly well-formed files; some cut short, corrupted, oversized or noise
  task automatic build_random_file();
    int          kind;
    int          n_ent;
    logic [31:0] cnt;
    logic [31:0] sz;
    logic [31:0] id;
    logic [31:0] sizes[$];
    bit          short_lump;
    int          spot;
    file_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 94) begin
      add_random($urandom_range(1, 20));
      return;
    end
    cnt = $urandom_range(0, (cfg_max_count < 6) ? cfg_max_count : 6);
    if (kind >= 88) cnt = $urandom_range(0, 1) ? cfg_max_count + 1 + $urandom_range(0, 20)
                                               : $urandom;
    add_word(MAGIC_WORD);
    add_word(cfg_version);
    add_word(cnt);
    n_ent = (cnt <= 6) ? cnt : 2;
    for (int k = 0; k < n_ent; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: sz = 0;
        3:       sz = $urandom | 32'h100;
        default: sz = $urandom_range(1, 9);
      endcase
      case ($urandom_range(0, 7))
        0:       id = '0;
        1:       id = '1;
        default: id = $urandom;
      endcase
      add_word(id);
      add_word(sz);
      sizes.push_back(sz);
    end
    short_lump = 1'b0;
    foreach (sizes[k]) begin
      if (!short_lump && sizes[k] != 0) add_lump(sizes[k], short_lump);
    end
    if (!short_lump) add_random($urandom_range(0, 3));
    if (kind >= 65 && kind < 80) keep_first($urandom_range(1, file_bytes.size()));
    if (kind >= 80 && kind < 88) begin
      spot = $urandom_range(0, HDR_BYTES - 1);
      file_bytes[spot] = file_bytes[spot] ^ (8'd1 << $urandom_range(0, 7));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  initial begin : run
    dir_row_t  rows[15];
    logic [31:0] round_ver[6];
    logic [7:0]  round_max[6];
    int          round_send[6];
    int          round_recv[6];
    int          sent;

    cfg_version = EXPECTED_VERSION_RST;
    cfg_max_count = LUMP_LIMIT_RST;
    clear_parse();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed files at reset settings
    rows = '{
      '{MAGIC_WORD, EXPECTED_VERSION_RST, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK},
      '{MAGIC_WORD, EXPECTED_VERSION_RST, 0, 0, 0, 0, 0, 1, 0, 1, ST_TOO_SMALL},
      '{32'h0, EXPECTED_VERSION_RST, 0, 0, 0, 0, 0, 11, 0, 1, ST_TOO_SMALL},
      '{32'hFFFF_FFFF, EXPECTED_VERSION_RST, 0, 0, 0, 0, 0, 0, 2, 1, ST_BAD_MAGIC},
      '{MAGIC_WORD, 32'd23, 0, 0, 0, 0, 0, 0, 1, 1, ST_BAD_VER},
      '{MAGIC_WORD, EXPECTED_VERSION_RST, 101, 0, 0, 0, 0, 0, 2, 1, ST_COUNT_BIG},
      '{MAGIC_WORD, EXPECTED_VERSION_RST, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 1, ST_COUNT_BIG},
      '{MAGIC_WORD, EXPECTED_VERSION_RST, 2, 7, 4, 4, 0, 20, 0, 1, ST_TBL_TRUNC},
      '{MAGIC_WORD, EXPECTED_VERSION_RST, 1, 9, 5, 0, 0, 22, 0, 1, ST_LUMP_END},
      '{MAGIC_WORD, EXPECTED_VERSION_RST, 1, 9, 5, 0, 0, 26, 0, 1, ST_PAD_END},
      '{MAGIC_WORD, EXPECTED_VERSION_RST, 1, 3, 3, 0, 0, 20, 0, 1, ST_LUMP_END},
      '{MAGIC_WORD, EXPECTED_VERSION_RST, 3, 32'hFFFF_FFFF, 4, 0, 1, 0, 3, 1, ST_OK},
      '{MAGIC_WORD, EXPECTED_VERSION_RST, 3, 0, 0, 0, 0, 0, 0, 1, ST_OK},
      '{MAGIC_WORD, EXPECTED_VERSION_RST, 2, 5, 32'hFFFF_FFFF, 2, 0, 31, 0, 1, ST_LUMP_END},
      '{MAGIC_WORD, EXPECTED_VERSION_RST, 100, 1, 1, 2, 3, 30, 0, 1, ST_TBL_TRUNC}
    };
    send_pct = 36;
    recv_pct = 77;
    foreach (rows[k]) begin
      build_row(rows[k]);
      send_file('{rows[k].typed, rows[k].want});
    end
    wait_drained();

    // Random rounds over register settings and idle patterns
    round_ver = '{32'h0, 32'hFFFF_FFFF, $urandom, EXPECTED_VERSION_RST, $urandom, $urandom};
    round_max = '{8'd0, 8'd128, 8'($urandom_range(1, 8)), LUMP_LIMIT_RST, 8'd5, 8'd128};
    round_send = '{36, 36, 77, 77, 0, 0};
    round_recv = '{77, 77, 36, 36, 0, 0};
    for (int r = 0; r < 6; r++) begin
      set_reg(REG_EXPECTED_VERSION, round_ver[r]);
      set_reg(REG_LUMP_LIMIT, {24'd0, round_max[r]});
      send_pct = round_send[r];
      recv_pct = round_recv[r];
      if (r == 1) begin
        // full-depth count is accepted; the file then ends inside the table
        build_big_table(DEPTH);
        keep_first(HDR_BYTES + 40);
        send_file('{1'b1, ST_TBL_TRUNC});
        build_big_table(DEPTH + 1);
        send_file('{1'b1, ST_COUNT_BIG});
      end
      sent = 0;
      while (sent < ROUND_BYTES) begin
        build_random_file();
        sent += file_bytes.size();
        send_file('{1'b0, ST_OK});
      end
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (pending.size() != 0) begin
      $error("%0d expected result items never arrived", pending.size());
      mismatches++;
    end
    $display("covered %0d bytes in %0d files, %0d lump payload bytes out",
             n_bytes, n_files, n_payload);
    $display("final status codes reached (bit per code): %b", seen_status);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: bsp_lump_container_parser_core.f
rtl/core/bcp_pkg.sv
rtl/core/bcp_table_mem.sv
rtl/core/bcp_out_buf.sv
rtl/core/bcp_parser.sv
rtl/core/bsp_lump_container_parser_core.sv
tb/sv/bsp_lump_container_parser_core_test.sv
